// ----- sv/assert_macros.svh -----
// Assertion macros shared by the scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tps_pkg.sv -----
// ---------------------------------------------------------------------------
// Scheduler package
// Shared types and codes of the process scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tps_pkg;
    localparam logic [2:0] EV_ADMIT = 3'd0;
    localparam logic [2:0] EV_WAIT  = 3'd1;
    localparam logic [2:0] EV_DROP  = 3'd2;
    localparam logic [2:0] EV_IDLE  = 3'd3;
    localparam logic [2:0] EV_RAN   = 3'd4;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SRTF = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;

    localparam logic [1:0] CFG_POLICY  = 2'd0;
    localparam logic [1:0] CFG_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_LIMIT   = 2'd2;

    // One entry of the ready table.
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  burst;
        logic [7:0]  rem;
        logic [15:0] arr;
        logic        started;
        logic [15:0] first;
    } entry_t;

    // One entry of the waiting FIFO.
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  burst;
        logic [15:0] arr;
    } wentry_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  ran_id;
        logic        first_run;
        logic        dispatched;
        logic        finished;
        logic [15:0] turnaround;
        logic [15:0] wait_time;
        logic [15:0] response;
        logic        promoted_valid;
        logic [7:0]  promoted_id;
    } result_t;
endpackage

// ----- sv/tick_process_scheduler.sv -----
// ---------------------------------------------------------------------------
// Tick process scheduler
// FCFS, SRTF and round robin process scheduler driven by arrival and tick
// transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
// One transaction is handled at a time. An arrival is answered straight from
// the idle state. A tick under FCFS or round robin serves the head of the
// queue order, plus, on finish, a shift of the queue order and the removal
// and promotion, and, for round robin at the end of a slice, a rotation of
// the queued processes. Under SRTF a tick scans every ready process through
// the one read port of the table memory, then rotates the order, before any
// finish work. The result is held in an output register; the next
// transaction is taken once it has been delivered.
module tick_process_scheduler #(
    parameter int READY_DEPTH = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_proc_id,
    input  logic [7:0]  s_burst,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_ran_id,
    output logic        m_first_run,
    output logic        m_dispatched,
    output logic        m_finished,
    output logic [15:0] m_turnaround,
    output logic [15:0] m_wait_time,
    output logic [15:0] m_response,
    output logic        m_promoted_valid,
    output logic [7:0]  m_promoted_id
);
    import tps_pkg::*;

    logic [1:0] policy_reg;
    logic [7:0] quantum_reg;
    logic [4:0] limit_reg;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FCFS;
            quantum_reg <= 8'd4;
            limit_reg <= 5'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_POLICY:  policy_reg <= cfg_data[1:0];
                CFG_QUANTUM: quantum_reg <= cfg_data;
                CFG_LIMIT:   limit_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    tps_core #(.READY_DEPTH(READY_DEPTH), .WAIT_DEPTH(WAIT_DEPTH)) u_core (
        .aclk(aclk), .aresetn(aresetn),
        .policy((policy_reg == 2'd3) ? POL_FCFS : policy_reg),
        .quantum(quantum_reg), .ready_limit(limit_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_cmd(s_command),
        .in_id(s_proc_id), .in_burst(s_burst),
        .res_valid(m_valid), .res_ready(m_ready), .res(res)
    );

    assign m_event_res = res.event_res;
    assign m_ran_id = res.ran_id;
    assign m_first_run = res.first_run;
    assign m_dispatched = res.dispatched;
    assign m_finished = res.finished;
    assign m_turnaround = res.turnaround;
    assign m_wait_time = res.wait_time;
    assign m_response = res.response;
    assign m_promoted_valid = res.promoted_valid;
    assign m_promoted_id = res.promoted_id;
endmodule

// ----- sv/tps_wait_fifo.sv -----
// ---------------------------------------------------------------------------
// Waiting FIFO
// Circular store of processes that could not be admitted, with a
// registered head read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tps_wait_fifo #(
    parameter int WAIT_DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tps_pkg::wentry_t push_data,
    input  logic             pop,
    output tps_pkg::wentry_t head_data,
    output logic [$clog2(WAIT_DEPTH+1)-1:0] count
);
    import tps_pkg::*;
    `include "assert_macros.svh"

    localparam int PW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);

    wentry_t        mem [WAIT_DEPTH];
    logic [PW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  tail;
    logic [PW:0]    tail_sum;

    assign tail_sum = {1'b0, head_reg} + (PW+1)'(count_reg);
    assign tail = (tail_sum >= (PW+1)'(WAIT_DEPTH)) ?
                  PW'(tail_sum - (PW+1)'(WAIT_DEPTH)) : PW'(tail_sum);

    always_comb begin
        head_next = head_reg;
        count_next = count_reg;
        if (pop) begin
            head_next = (head_reg == PW'(WAIT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else if (push) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            count_reg <= '0;
        end else begin
            head_reg <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail] <= push_data;
        end
        head_data <= mem[head_next];
    end

    assign count = count_reg;

    `ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, count_reg < CW'(WAIT_DEPTH), "push on full FIFO")
    `ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, count_reg != '0, "pop on empty FIFO")
endmodule

// ----- sv/tps_core.sv -----
// ---------------------------------------------------------------------------
// Scheduler core
// Sequencer that keeps the ready table and queue order in memories and
// serves one transaction at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tps_core #(
    parameter int READY_DEPTH = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        policy,
    input  logic [7:0]        quantum,
    input  logic [4:0]        ready_limit,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_cmd,
    input  logic [7:0]        in_id,
    input  logic [7:0]        in_burst,
    output logic              res_valid,
    input  logic              res_ready,
    output tps_pkg::result_t  res
);
    import tps_pkg::*;
    `include "assert_macros.svh"

    localparam int SW = $clog2(READY_DEPTH);
    localparam int RCW = $clog2(READY_DEPTH + 1);
    localparam int WCW = $clog2(WAIT_DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;  // read order[i]
    localparam logic [3:0] S_SCANW  = 4'd2;  // order data back; read entry
    localparam logic [3:0] S_SCANC  = 4'd3;  // entry data back; compare
    localparam logic [3:0] S_ROT    = 4'd4;  // read order for rotate
    localparam logic [3:0] S_ROTW   = 4'd5;
    localparam logic [3:0] S_SERVE  = 4'd6;  // read order at chosen position
    localparam logic [3:0] S_SERVEW = 4'd7;
    localparam logic [3:0] S_UPD    = 4'd8;
    localparam logic [3:0] S_REM    = 4'd9;  // shift order down after finish
    localparam logic [3:0] S_REMW   = 4'd10;
    localparam logic [3:0] S_PROM   = 4'd11;
    localparam logic [3:0] S_RRROT  = 4'd13;

    // Memories: ready table entries and queue order.
    entry_t        tab [READY_DEPTH];
    logic [SW-1:0] ord [READY_DEPTH];
    logic [SW-1:0] tab_raddr, tab_waddr, ord_raddr, ord_waddr;
    logic          tab_we, ord_we;
    entry_t        tab_wdata, tab_rdata;
    logic [SW-1:0] ord_wdata, ord_rdata;

    always_ff @(posedge aclk) begin
        if (tab_we) tab[tab_waddr] <= tab_wdata;
        tab_rdata <= tab[tab_raddr];
    end
    always_ff @(posedge aclk) begin
        if (ord_we) ord[ord_waddr] <= ord_wdata;
        ord_rdata <= ord[ord_raddr];
    end

    // Slot occupancy flags (a bitmap, each read at its own place).
    logic [READY_DEPTH-1:0] used_reg, used_next;
    logic [SW-1:0]          free_slot;
    always_comb begin
        free_slot = '0;
        for (int k = READY_DEPTH - 1; k >= 0; k--) begin
            if (!used_reg[k]) free_slot = SW'(k);
        end
    end

    logic [3:0]     state_reg, state_next;
    logic [RCW-1:0] cnt_reg, cnt_next;
    logic [15:0]    now_reg, now_next;
    logic [7:0]     slice_reg, slice_next;
    logic           act_reg, act_next;
    logic [SW-1:0]  cur_reg, cur_next;
    logic [RCW-1:0] idx_reg, idx_next;     // scan / rotate index
    logic [RCW-1:0] best_reg, best_next;   // position of best
    logic [SW-1:0]  bslot_reg, bslot_next;
    logic [7:0]     brem_reg, brem_next;
    logic [15:0]    bage_reg, bage_next;
    logic [SW-1:0]  slot_reg, slot_next;   // order data captured in scan and serve
    logic [RCW-1:0] rot_reg, rot_next;     // rotate amount
    logic           fin_reg, fin_next;
    logic           disp_reg, disp_next;
    logic           rv_reg, rv_next;
    result_t        res_reg, res_next;
    logic [SW-1:0]  hold_slot [READY_DEPTH];  // rotation buffer
    logic           hold_we;
    logic [SW-1:0]  hold_waddr;

    logic          wpush, wpop;
    wentry_t       wpush_data;
    wentry_t       whead;
    logic [WCW-1:0] wcount;

    assign wpush_data.id = in_id;
    assign wpush_data.burst = in_burst;
    assign wpush_data.arr = now_reg;

    tps_wait_fifo #(.WAIT_DEPTH(WAIT_DEPTH)) u_wait (
        .aclk(aclk), .aresetn(aresetn), .push(wpush),
        .push_data(wpush_data),
        .pop(wpop), .head_data(whead), .count(wcount)
    );

    always_ff @(posedge aclk) begin
        if (hold_we) hold_slot[hold_waddr] <= ord_rdata;
    end

    logic [RCW-1:0] limit;
    assign limit = (int'(ready_limit) > READY_DEPTH) ? RCW'(READY_DEPTH) : RCW'(ready_limit);

    logic [15:0] age;
    logic [RCW-1:0] rot_src;
    logic [RCW:0]   rsum;
    assign age = now_reg - tab_rdata.arr;
    assign rsum = {1'b0, idx_reg} + {1'b0, rot_reg};
    assign rot_src = (rsum >= {1'b0, cnt_reg}) ? RCW'(rsum - {1'b0, cnt_reg}) : RCW'(rsum);

    assign in_ready = (state_reg == S_IDLE) && !rv_reg;
    assign res_valid = rv_reg;
    assign res = res_reg;

    always_comb begin
        logic [7:0] q, len, nrem;
        entry_t e;
        state_next = state_reg; cnt_next = cnt_reg; now_next = now_reg;
        slice_next = slice_reg; act_next = act_reg; cur_next = cur_reg;
        idx_next = idx_reg; best_next = best_reg; bslot_next = bslot_reg;
        brem_next = brem_reg; bage_next = bage_reg; slot_next = slot_reg;
        rot_next = rot_reg; fin_next = fin_reg; disp_next = disp_reg;
        rv_next = rv_reg; res_next = res_reg; used_next = used_reg;
        tab_raddr = '0; tab_waddr = '0; tab_we = 1'b0; tab_wdata = tab_rdata;
        ord_raddr = '0; ord_waddr = '0; ord_we = 1'b0; ord_wdata = '0;
        hold_we = 1'b0; hold_waddr = '0;
        wpush = 1'b0; wpop = 1'b0;
        q = '0; len = '0; nrem = '0; e = tab_rdata;
        if (rv_reg && res_ready) rv_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    res_next = '0;
                    if (!in_cmd) begin
                        if (cnt_reg < limit) begin
                            e = '0;
                            e.id = in_id; e.burst = in_burst; e.rem = in_burst;
                            e.arr = now_reg;
                            tab_we = 1'b1; tab_waddr = free_slot; tab_wdata = e;
                            ord_we = 1'b1; ord_waddr = SW'(cnt_reg); ord_wdata = free_slot;
                            used_next[free_slot] = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            res_next.event_res = EV_ADMIT;
                        end else if (wcount < WCW'(WAIT_DEPTH)) begin
                            wpush = 1'b1;
                            res_next.event_res = EV_WAIT;
                        end else begin
                            res_next.event_res = EV_DROP;
                        end
                        rv_next = 1'b1;
                    end else if (cnt_reg == '0) begin
                        res_next.event_res = EV_IDLE;
                        act_next = 1'b0; slice_next = '0;
                        now_next = now_reg + 1'b1;
                        rv_next = 1'b1;
                    end else if (policy == POL_SRTF) begin
                        idx_next = '0;
                        state_next = S_SCAN;
                    end else begin
                        ord_raddr = '0;
                        best_next = '0;
                        state_next = S_SERVE;
                    end
                end
            end
            S_SCAN: begin
                ord_raddr = SW'(idx_reg);
                state_next = S_SCANW;
            end
            S_SCANW: begin
                tab_raddr = ord_rdata;
                slot_next = ord_rdata;
                state_next = S_SCANC;
            end
            S_SCANC: begin
                if (idx_reg == '0 || tab_rdata.rem < brem_reg ||
                    (tab_rdata.rem == brem_reg && age > bage_reg)) begin
                    best_next = idx_reg; bslot_next = slot_reg;
                    brem_next = tab_rdata.rem; bage_next = age;
                end
                if (idx_reg + 1'b1 == cnt_reg) begin
                    rot_next = (best_next + 1'b1 == cnt_reg) ? '0 : best_next + 1'b1;
                    idx_next = '0;
                    state_next = S_ROT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            // Rotation: copy order through the hold buffer, then write back.
            S_ROT: begin
                ord_raddr = SW'(rot_src);
                state_next = S_ROTW;
            end
            S_ROTW: begin
                hold_we = 1'b1; hold_waddr = SW'(idx_reg);
                if (idx_reg + 1'b1 == cnt_reg) begin
                    idx_next = '0;
                    state_next = S_RRROT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_ROT;
                end
            end
            S_RRROT: begin
                ord_we = 1'b1; ord_waddr = SW'(idx_reg); ord_wdata = hold_slot[SW'(idx_reg)];
                if (idx_reg + 1'b1 == cnt_reg) begin
                    if (fin_reg || disp_reg) begin
                        // Post-serve round robin rotation done.
                        fin_next = 1'b0; disp_next = 1'b0;
                        rv_next = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        best_next = cnt_reg - 1'b1;
                        ord_raddr = SW'(cnt_reg - 1'b1);
                        state_next = S_SERVE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // The chosen position is read here, after any rotation has been written back.
            S_SERVE: begin
                ord_raddr = SW'(best_reg);
                state_next = S_SERVEW;
            end
            S_SERVEW: begin
                tab_raddr = ord_rdata;
                slot_next = ord_rdata;
                state_next = S_UPD;
            end
            S_UPD: begin
                e = tab_rdata;
                res_next.event_res = EV_RAN;
                res_next.ran_id = e.id;
                if (policy == POL_SRTF) begin
                    res_next.dispatched = !act_reg || slot_reg != cur_reg;
                end else if (policy == POL_RR) begin
                    if (!(act_reg && slice_reg != '0 && slot_reg == cur_reg)) begin
                        q = (quantum == '0) ? 8'd1 : quantum;
                        len = (q < e.rem) ? q : e.rem;
                        slice_next = (len == '0) ? 8'd1 : len;
                        res_next.dispatched = 1'b1;
                    end
                end else begin
                    res_next.dispatched = !act_reg || slot_reg != cur_reg;
                end
                res_next.first_run = !e.started;
                if (!e.started) begin
                    e.started = 1'b1; e.first = now_reg;
                end
                nrem = (e.rem != '0) ? e.rem - 1'b1 : e.rem;
                e.rem = nrem;
                if (policy == POL_RR && slice_next != '0) slice_next = slice_next - 1'b1;
                tab_we = 1'b1; tab_waddr = slot_reg; tab_wdata = e;
                cur_next = slot_reg;
                now_next = now_reg + 1'b1;
                if (nrem == '0) begin
                    res_next.finished = 1'b1;
                    res_next.turnaround = now_next - e.arr;
                    res_next.wait_time = now_next - e.arr - {8'd0, e.burst};
                    res_next.response = e.first - e.arr;
                    used_next[slot_reg] = 1'b0;
                    act_next = 1'b0; slice_next = '0;
                    idx_next = best_reg;
                    state_next = S_REM;
                end else if (policy == POL_RR) begin
                    if (slice_next == '0) begin
                        act_next = 1'b0;
                        rot_next = (cnt_reg == RCW'(1)) ? '0 : RCW'(1);
                        idx_next = '0;
                        disp_next = 1'b1;
                        state_next = S_ROT;
                    end else begin
                        act_next = 1'b1;
                        rv_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    act_next = 1'b1; slice_next = '0;
                    rv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // Remove the finished position by shifting later entries down.
            S_REM: begin
                if (idx_reg + 1'b1 >= cnt_reg) begin
                    cnt_next = cnt_reg - 1'b1;
                    state_next = S_PROM;
                end else begin
                    ord_raddr = SW'(idx_reg + 1'b1);
                    state_next = S_REMW;
                end
            end
            S_REMW: begin
                ord_we = 1'b1; ord_waddr = SW'(idx_reg); ord_wdata = ord_rdata;
                idx_next = idx_reg + 1'b1;
                state_next = S_REM;
            end
            S_PROM: begin
                if (wcount != '0 && cnt_reg < RCW'(READY_DEPTH)) begin
                    e = '0;
                    e.id = whead.id; e.burst = whead.burst; e.rem = whead.burst;
                    e.arr = whead.arr;
                    tab_we = 1'b1; tab_waddr = free_slot; tab_wdata = e;
                    ord_we = 1'b1; ord_waddr = SW'(cnt_reg); ord_wdata = free_slot;
                    used_next[free_slot] = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    wpop = 1'b1;
                    res_next.promoted_valid = 1'b1;
                    res_next.promoted_id = whead.id;
                end
                rv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; cnt_reg <= '0; now_reg <= '0; slice_reg <= '0;
            act_reg <= 1'b0; cur_reg <= '0; rv_reg <= 1'b0; used_reg <= '0;
            fin_reg <= 1'b0; disp_reg <= 1'b0;
        end else begin
            state_reg <= state_next; cnt_reg <= cnt_next; now_reg <= now_next;
            slice_reg <= slice_next; act_reg <= act_next; cur_reg <= cur_next;
            rv_reg <= rv_next; used_reg <= used_next;
            fin_reg <= fin_next; disp_reg <= disp_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next; best_reg <= best_next; bslot_reg <= bslot_next;
        brem_reg <= brem_next; bage_reg <= bage_next; slot_reg <= slot_next;
        rot_reg <= rot_next; res_reg <= res_next;
    end

    `ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, cnt_reg <= RCW'(READY_DEPTH), "ready count overflow")
    `ASSERT_IMPL(a_used_count, aclk, aresetn, state_reg == S_IDLE, $countones(used_reg) == int'(cnt_reg), "slot map disagrees with count")
    `ASSERT_NEXT(a_res_hold, aclk, aresetn, rv_reg && !res_ready, rv_reg && $stable(res_reg), "result changed while stalled")
endmodule
